// File: hdl/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

	// Number of list cells, the widths that follow from it and the port widths
	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int POS_W = 7;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int VAL_W = 32;
	localparam int OUT_CNT_W = 7;

	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_END   = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_DEL_FIRST = 3'd3,
		OP_DEL_LAST  = 3'd4,
		OP_DEL_POS   = 3'd5,
		OP_WRITE     = 3'd6,
		OP_READ      = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// What every cell does in one cycle
	typedef enum logic [1:0] {
		CK_NOP = 2'd0,
		CK_INS = 2'd1,
		CK_DEL = 2'd2,
		CK_WR  = 2'd3
	} cell_kind_t;

	typedef struct packed {
		cell_kind_t         kind;
		logic               load;   // request accepted: capture read tap
		logic               rd_en;  // read request passed its checks
		logic [IDX_W-1:0]   idx;    // target cell
		logic [VAL_W-1:0]   value;
	} cell_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		status_t          status;
	} ctrl_res_t;

endpackage

// File: hdl/ple_cell.sv
// One list cell: holds an entry, shifts with its neighbors, taps it for reads.
module ple_cell import ple_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] idx,
	input  cell_cmd_t        cmd,
	input  logic [VAL_W-1:0] left_d,
	input  logic [VAL_W-1:0] right_d,
	output logic [VAL_W-1:0] d,
	output logic [VAL_W-1:0] rd
);

	logic [VAL_W-1:0] d_q;
	logic [VAL_W-1:0] rd_q;

	// Entry update: insert shifts toward the back, delete toward the front
	always_ff @(posedge clk) begin
		unique case (cmd.kind)
			CK_INS: begin
				if (idx > cmd.idx) begin
					d_q <= left_d;
				end else if (idx == cmd.idx) begin
					d_q <= cmd.value;
				end
			end
			CK_DEL: begin
				if (idx >= cmd.idx) begin
					d_q <= right_d;
				end
			end
			CK_WR: begin
				if (idx == cmd.idx) begin
					d_q <= cmd.value;
				end
			end
			CK_NOP: begin
			end
		endcase
	end

	// Read tap: only the addressed cell passes its entry, others give zero
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rd_q <= (cmd.rd_en && (idx == cmd.idx)) ? d_q : '0;
		end
	end

	assign d  = d_q;
	assign rd = rd_q;

endmodule

// File: hdl/ple_ctrl.sv
// Entry count, request checks and the command broadcast to the cells.
module ple_ctrl import ple_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [2:0]       op,
	input  logic [POS_W-1:0] pos,
	input  logic [VAL_W-1:0] value,
	output cell_cmd_t        cmd,
	output ctrl_res_t        res
);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] at;
	logic             full;
	logic             empty;
	cell_kind_t       kind;
	logic             rd_ok;
	status_t          st;

	assign cnt_x = CMP_W'(cnt_q);
	assign pos_x = CMP_W'(pos);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);

	// Decode and check the request against the current count
	always_comb begin
		kind  = CK_NOP;
		rd_ok = 1'b0;
		st    = ST_OK;
		at    = pos_x;
		cnt_d = cnt_q;
		unique case (op_t'(op))
			OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
				if (op_t'(op) == OP_INS_FRONT) begin
					at = '0;
				end else if (op_t'(op) == OP_INS_END) begin
					at = cnt_x;
				end
				if (full) begin
					st = ST_FULL;
				end else if (at > cnt_x) begin
					st = ST_BADPOS;
				end else begin
					kind  = CK_INS;
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_POS: begin
				if (op_t'(op) == OP_DEL_FIRST) begin
					at = '0;
				end else if (op_t'(op) == OP_DEL_LAST) begin
					at = cnt_x - CMP_W'(1);
				end
				if (empty) begin
					st = ST_EMPTY;
				end else if (at >= cnt_x) begin
					st = ST_BADPOS;
				end else begin
					kind  = CK_DEL;
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			OP_WRITE, OP_READ: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (at >= cnt_x) begin
					st = ST_BADPOS;
				end else if (op_t'(op) == OP_WRITE) begin
					kind = CK_WR;
				end else begin
					rd_ok = 1'b1;
				end
			end
		endcase
	end

	// Broadcast only when the request is taken
	always_comb begin
		cmd.kind  = accept ? kind : CK_NOP;
		cmd.load  = accept;
		cmd.rd_en = rd_ok;
		cmd.idx   = at[IDX_W-1:0];
		cmd.value = value;
	end

	assign res.count  = cnt_d;
	assign res.status = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= cnt_d;
		end
	end

endmodule

// File: hdl/positional_list_engine_top.sv
// Top level of the positional list engine: cell chain and result stages.
//
// An ordered list of signed 32-bit entries, front at position 0, held in a
// row of DEPTH cells (64). Each request on the input channel (op, pos,
// value) inserts, removes, overwrites or reads one entry; every request
// yields exactly one result (read_value, count, status) on the output
// channel, in order. Flagged requests (bad position, full, empty) leave
// the list unchanged; read_value is zero except on a successful read.
// Inserts and removes shift all cells behind the target in parallel in
// the cycle the request is taken, so a request is accepted every cycle
// while in_stall is low. The read tap in each cell and the middle stage
// load at the edge that takes the request, and the output register
// behind the OR of the taps takes them from there and presents the result.
// When the receiver stalls, the result register holds; one more request
// may sit in the middle stage, after which in_stall rises until the
// output drains.
// Reset clears the count (empty list) and both stage valids; entry
// contents are not cleared and are never read before written.
module positional_list_engine_top import ple_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [2:0]              op,
	input  logic [POS_W-1:0]        pos,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] read_value,
	output logic [OUT_CNT_W-1:0]    count,
	output logic [1:0]              status
);

	logic             accept;
	logic             out_adv;
	logic             vld_s1;
	ctrl_res_t        res_s1;
	ctrl_res_t        res;
	cell_cmd_t        cmd;
	logic             out_vld_q;
	logic [VAL_W-1:0] rdv_q;
	logic [OUT_CNT_W-1:0] cnt_q;
	status_t          st_q;
	logic [VAL_W-1:0] cell_d  [DEPTH];
	logic [VAL_W-1:0] cell_rd [DEPTH];
	logic [VAL_W-1:0] rd_or;

	// Handshake
	assign out_adv  = !out_vld_q || !out_stall;
	assign in_stall = vld_s1 && !out_adv;
	assign accept   = in_valid && !in_stall;

	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (op),
		.pos    (pos),
		.value  (value),
		.cmd    (cmd),
		.res    (res)
	);

	// Chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left_d;
		logic [VAL_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_d[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_d[i];
		end else begin : g_mid_r
			assign right_d = cell_d[i+1];
		end
		ple_cell u_cell (
			.clk     (clk),
			.idx     (IDX_W'(i)),
			.cmd     (cmd),
			.left_d  (left_d),
			.right_d (right_d),
			.d       (cell_d[i]),
			.rd      (cell_rd[i])
		);
	end

	// Merge the read taps; at most one is nonzero
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	// Middle stage: status and count wait beside the read taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (out_adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && vld_s1) begin
			rdv_q <= rd_or;
			cnt_q <= OUT_CNT_W'(res_s1.count);
			st_q  <= res_s1.status;
		end
	end

	assign out_valid  = out_vld_q;
	assign read_value = rdv_q;
	assign count      = cnt_q;
	assign status     = st_q;

endmodule

// File: hdl/ple_chk.sv
// Port-level checks for the positional list engine, bound to the top level.
module ple_chk import ple_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [VAL_W-1:0] read_value,
	input logic [OUT_CNT_W-1:0]    count,
	input logic [1:0]              status
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(read_value) && $stable(count) && $stable(status))
		else $error("stalled result changed");

	// Empty status only reports an empty list
	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY) |-> (count == '0))
		else $error("empty status with nonzero count");

	// Full status only reports a full list
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (count == OUT_CNT_W'(DEPTH)))
		else $error("full status with count below depth");

	// A value is only returned on a good request
	a_rd_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_value != '0) |-> (status == ST_OK))
		else $error("read value on a flagged request");

endmodule

bind positional_list_engine_top ple_chk u_ple_chk (.*);

// File: bench/tb_top.sv
// Testbench for the positional list engine: random and directed list requests with a checker.
module tb_top;
	import ple_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT    = 22;
	localparam int QUIET_LIMIT = 2000;
	localparam int RAND_REQS   = 1375;
	localparam int CALM_LO     = 600;
	localparam int CALM_HI     = 900;

	typedef struct {
		op_t                     op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] value;
	} list_req_t;

	typedef struct {
		logic signed [VAL_W-1:0] read_value;
		logic [OUT_CNT_W-1:0]    count;
		status_t                 status;
	} list_res_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [2:0]              op;
	logic [POS_W-1:0]        pos;
	logic signed [VAL_W-1:0] value;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [VAL_W-1:0] read_value;
	logic [OUT_CNT_W-1:0]    count;
	logic [1:0]              status;

	positional_list_engine_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.pos        (pos),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.count      (count),
		.status     (status)
	);

	list_req_t pending_reqs[$];
	list_res_t expected_results[$];

	// Shadow list that predicts every result
	logic signed [VAL_W-1:0] shadow_cells [DEPTH];
	int unsigned             shadow_count;

	// Entry count seen by the generator, used to aim positions
	int unsigned gen_count;

	bit        running;
	int        reqs_taken;
	int        error_count;
	int        quiet_cycles;
	list_req_t drv_next;
	list_res_t mon_exp;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Insert into the shadow list, shifting the tail back by one cell
	function automatic status_t shadow_insert(int unsigned at, logic signed [VAL_W-1:0] v);
		if (shadow_count >= DEPTH)
			return ST_FULL;
		if (at > shadow_count)
			return ST_BADPOS;
		for (int unsigned i = shadow_count; i > at; i--)
			shadow_cells[i] = shadow_cells[i-1];
		shadow_cells[at] = v;
		shadow_count++;
		return ST_OK;
	endfunction

	// Remove from the shadow list, shifting the tail forward by one cell
	function automatic status_t shadow_remove(int unsigned at);
		if (shadow_count == 0)
			return ST_EMPTY;
		if (at >= shadow_count)
			return ST_BADPOS;
		for (int unsigned i = at; i + 1 < shadow_count; i++)
			shadow_cells[i] = shadow_cells[i+1];
		shadow_count--;
		return ST_OK;
	endfunction

	// Apply one accepted request to the shadow list and queue its result
	function automatic void predict_list_op(op_t o, logic [POS_W-1:0] p,
			logic signed [VAL_W-1:0] v);
		list_res_t r;
		r.read_value = '0;
		r.status = ST_OK;
		case (o)
			OP_INS_FRONT: r.status = shadow_insert(0, v);
			OP_INS_END:   r.status = shadow_insert(shadow_count, v);
			OP_INS_POS:   r.status = shadow_insert(p, v);
			OP_DEL_FIRST: r.status = shadow_remove(0);
			OP_DEL_LAST:  r.status = (shadow_count == 0) ? ST_EMPTY
				: shadow_remove(shadow_count - 1);
			OP_DEL_POS:   r.status = shadow_remove(p);
			OP_WRITE: begin
				if (shadow_count == 0)
					r.status = ST_EMPTY;
				else if (p >= shadow_count)
					r.status = ST_BADPOS;
				else
					shadow_cells[p] = v;
			end
			default: begin
				if (shadow_count == 0)
					r.status = ST_EMPTY;
				else if (p >= shadow_count)
					r.status = ST_BADPOS;
				else
					r.read_value = shadow_cells[p];
			end
		endcase
		r.count = shadow_count[OUT_CNT_W-1:0];
		expected_results.push_back(r);
	endfunction

	// Queue a request and track the count it leaves behind
	function automatic void queue_req(op_t o, int p, logic signed [VAL_W-1:0] v);
		list_req_t q;
		q.op = o;
		q.pos = p[POS_W-1:0];
		q.value = v;
		pending_reqs.push_back(q);
		case (o)
			OP_INS_FRONT, OP_INS_END: if (gen_count < DEPTH) gen_count++;
			OP_INS_POS:   if (gen_count < DEPTH && q.pos <= gen_count) gen_count++;
			OP_DEL_FIRST, OP_DEL_LAST: if (gen_count > 0) gen_count--;
			OP_DEL_POS:   if (gen_count > 0 && q.pos < gen_count) gen_count--;
			default: ;
		endcase
	endfunction

	// Position aimed mostly inside the list, sometimes at or past its end
	function automatic int pick_pos(op_t o);
		int lim;
		int r;
		lim = (o == OP_INS_POS) ? gen_count + 1 : gen_count;
		r = $urandom_range(99);
		if (r < 60 && lim > 0)
			return $urandom_range(lim - 1);
		if (r < 70)
			return gen_count;
		if (r < 80)
			return (gen_count + 1 > 127) ? 127 : gen_count + 1;
		return $urandom_range(127);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return 32'sh0000_0000;
				default: return 32'shFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	function automatic bit take_break();
		if (reqs_taken >= CALM_LO && reqs_taken < CALM_HI)
			return 1'b0;
		return $urandom_range(99) < IDLE_PCT;
	endfunction

	// Request driver
	always @(posedge clk) begin
		if (running) begin
			if (in_valid && !in_stall) begin
				predict_list_op(op_t'(op), pos, value);
				reqs_taken <= reqs_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && !take_break()) begin
					drv_next = pending_reqs.pop_front();
					in_valid <= 1'b1;
					op       <= drv_next.op;
					pos      <= drv_next.pos;
					value    <= drv_next.value;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and random receiver stall
	always @(posedge clk) begin
		if (running) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result: value %h count %0d status %0d",
							read_value, count, status);
				end else begin
					mon_exp = expected_results.pop_front();
					if (read_value !== mon_exp.read_value || count !== mon_exp.count ||
							status !== mon_exp.status) begin
						error_count++;
						if (error_count <= 10)
							$display("mismatch: exp value %h count %0d status %0d, got value %h count %0d status %0d",
								mon_exp.read_value, mon_exp.count, mon_exp.status,
								read_value, count, status);
					end
				end
			end
			out_stall <= take_break();
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (running) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int   mode;
		int   r;
		op_t  o;

		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = '0;
		pos = '0;
		value = '0;
		out_stall = 1'b0;
		running = 1'b0;
		reqs_taken = 0;
		error_count = 0;
		quiet_cycles = 0;
		shadow_count = 0;
		gen_count = 0;
		for (int i = 0; i < DEPTH; i++)
			shadow_cells[i] = '0;

		// Directed: empty-list flags, append at the count, value extremes, bad positions
		queue_req(OP_READ, 0, 0);
		queue_req(OP_DEL_FIRST, 0, 0);
		queue_req(OP_DEL_LAST, 0, 0);
		queue_req(OP_DEL_POS, 0, 0);
		queue_req(OP_WRITE, 0, 1);
		queue_req(OP_INS_POS, 1, 2);
		queue_req(OP_INS_POS, 0, 32'sh7FFF_FFFF);
		queue_req(OP_INS_FRONT, 0, 32'sh8000_0000);
		queue_req(OP_INS_END, 127, 0);
		queue_req(OP_INS_END, 0, -1);
		queue_req(OP_INS_POS, 2, 32'sh1234_5678);
		queue_req(OP_READ, 5, 0);
		queue_req(OP_READ, 127, 0);
		for (int i = 0; i < 5; i++)
			queue_req(OP_READ, i, 0);
		queue_req(OP_WRITE, 5, 3);
		queue_req(OP_WRITE, 4, 32'sh5555_5555);
		queue_req(OP_DEL_POS, 5, 0);
		queue_req(OP_DEL_POS, 2, 0);
		queue_req(OP_DEL_LAST, 0, 0);
		queue_req(OP_DEL_FIRST, 0, 0);
		queue_req(OP_READ, 0, 0);

		// Random: fill, drain and mixed blocks so the list hits both full and empty
		for (int i = 0; i < RAND_REQS; i++) begin
			mode = (i / 200) % 3;
			r = $urandom_range(99);
			if (mode == 2) begin
				o = op_t'($urandom_range(7));
			end else if (r < 20) begin
				o = r[0] ? OP_WRITE : OP_READ;
			end else if ((mode == 0) == (r < 85)) begin
				o = op_t'($urandom_range(2));
			end else begin
				o = op_t'($urandom_range(5, 3));
			end
			queue_req(o, pick_pos(o), pick_value());
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1'b1;

		// Wait for all requests and results, then let the pipeline settle
		@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		error_count += expected_results.size();

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: positional_list_engine_top.f
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/ple_ctrl.sv
hdl/positional_list_engine_top.sv
hdl/ple_chk.sv
bench/tb_top.sv
